// File: rtl/otmc_pkg.sv
// Shared types and constants for the oven timer mode controller.
package otmc_pkg;

    // Key codes
    localparam logic [7:0] KEY_A       = 8'd65;
    localparam logic [7:0] KEY_B       = 8'd66;
    localparam logic [7:0] KEY_C       = 8'd67;
    localparam logic [7:0] KEY_D       = 8'd68;
    localparam logic [7:0] DIGIT_LIMIT = 8'd10;

    // Largest time that can be entered, in seconds
    localparam logic [13:0] TIME_MAX = 14'd9999;

    // Mode codes
    localparam logic [2:0] MODE_SET  = 3'd0;
    localparam logic [2:0] MODE_HEAT = 3'd1;
    localparam logic [2:0] MODE_DOOR = 3'd2;
    localparam logic [2:0] MODE_FOOD = 3'd3;
    localparam logic [2:0] MODE_BOTH = 3'd4;

    // Configuration registers
    localparam int         CFG_IDX_W  = 2;
    localparam logic [1:0] CFG_PPS    = 2'd0;
    localparam logic [1:0] CFG_IDLE   = 2'd1;
    localparam logic [7:0] PPS_RESET  = 8'd5;
    localparam logic [7:0] IDLE_RESET = 8'd50;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_key;
        logic step;
        logic rb_step;
        logic out_load;
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic rb_needed;
        logic rb_last;
    } dp_status_t;

endpackage

// File: rtl/otmc_ctrl.sv
// Controller state machine: sequences key update, digit rebuild and result hand-off.
module otmc_ctrl
    import otmc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    output ctrl_cmd_t  cmd,
    input  dp_status_t status
);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_STEP    = 4'b0010,
        ST_REBUILD = 4'b0100,
        ST_FINISH  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_key = 1'b1;
                    state_next   = ST_STEP;
                end
            end
            ST_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = status.rb_needed ? ST_REBUILD : ST_FINISH;
            end
            ST_REBUILD:
            begin
                cmd.rb_step = 1'b1;
                if (status.rb_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output word valid: set on load, cleared once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/otmc_dp.sv
// Datapath: flags, mode, times, counters, digit store, rebuild unit and result register.
module otmc_dp
    import otmc_pkg::*;
#(
    parameter int MAX_DIGITS = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           key_code,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status,
    output logic [2:0]           mode,
    output logic                 heating_on,
    output logic                 door_open,
    output logic                 no_food,
    output logic [13:0]          entered_time,
    output logic [13:0]          time_left
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    // Configuration
    logic [7:0] pps_reg, idle_reg;

    // Controller state
    logic [7:0]  key_reg;
    logic [2:0]  mode_reg, mode_next;
    logic        heat_reg, heat_next;
    logic        door_reg, door_next;
    logic        food_reg, food_next;
    logic [13:0] set_reg, set_next;
    logic [13:0] left_reg, left_next;
    logic [7:0]  period_reg, period_next;
    logic [7:0]  press_reg, press_next;
    logic [3:0]  digit_reg [MAX_DIGITS];
    logic [3:0]  digit_next [MAX_DIGITS];
    logic [IDX_W-1:0] rb_idx_reg, rb_idx_next;
    logic [IDX_W-1:0] rb_end_reg, rb_end_next;

    // Step decode
    logic is_a, is_b, is_c, is_d, is_digit;
    logic food_n, door_n;
    logic room_left, idle_hit;
    logic rb_needed;
    logic [16:0] acc_wide;
    logic [13:0] acc_sat;

    assign is_a      = (key_reg == KEY_A);
    assign is_b      = (key_reg == KEY_B);
    assign is_c      = (key_reg == KEY_C);
    assign is_d      = (key_reg == KEY_D);
    assign is_digit  = (key_reg < DIGIT_LIMIT);
    assign food_n    = food_reg ^ is_a;
    assign door_n    = door_reg ^ is_b;
    assign room_left = (press_reg < 8'(MAX_DIGITS));

    // One rebuild iteration: acc * 10 + digit, held at the time limit
    assign acc_wide = ({3'b000, set_reg} << 3) + ({3'b000, set_reg} << 1)
                    + {13'd0, digit_reg[rb_idx_reg]};
    assign acc_sat  = (acc_wide > 17'(TIME_MAX)) ? TIME_MAX : acc_wide[13:0];

    // Status to the controller
    assign status = '{rb_needed: rb_needed, rb_last: (rb_idx_reg == rb_end_reg)};

    // Per-word mode update
    always_comb
    begin
        mode_next   = mode_reg;
        heat_next   = heat_reg;
        door_next   = door_reg;
        food_next   = food_reg;
        set_next    = set_reg;
        left_next   = left_reg;
        period_next = period_reg;
        press_next  = press_reg;
        digit_next  = digit_reg;
        rb_idx_next = rb_idx_reg;
        rb_end_next = rb_end_reg;
        idle_hit    = 1'b0;
        rb_needed   = 1'b0;

        if (cmd.step)
        begin
            food_next   = food_n;
            door_next   = door_n;
            period_next = period_reg + 8'd1;
            if (mode_reg == MODE_HEAT)
            begin
                if (is_b)
                begin
                    heat_next = 1'b0;
                    mode_next = MODE_DOOR;
                    set_next  = left_reg;
                end
                else if (is_c || (left_reg == 14'd0))
                begin
                    set_next    = 14'd0;
                    period_next = 8'd0;
                    press_next  = 8'd0;
                    mode_next   = MODE_SET;
                    heat_next   = 1'b0;
                end
                // second tick
                if (period_next == pps_reg)
                begin
                    period_next = 8'd0;
                    if (left_reg != 14'd0)
                    begin
                        left_next = left_reg - 14'd1;
                    end
                end
            end
            else
            begin
                if (is_digit)
                begin
                    period_next = 8'd0;
                    mode_next   = MODE_SET;
                    if (room_left)
                    begin
                        digit_next[press_reg[IDX_W-1:0]] = key_reg[3:0];
                    end
                    press_next = press_reg + 8'd1;
                end
                else if (is_c)
                begin
                    set_next    = 14'd0;
                    period_next = 8'd0;
                    press_next  = 8'd0;
                    mode_next   = MODE_SET;
                end
                else if (is_d)
                begin
                    period_next = 8'd0;
                    if (set_reg != 14'd0)
                    begin
                        if (!food_n && !door_n)
                        begin
                            left_next = set_reg;
                            heat_next = 1'b1;
                            mode_next = MODE_HEAT;
                        end
                        else
                        begin
                            heat_next = 1'b0;
                            if (!food_n)
                            begin
                                mode_next = MODE_DOOR;
                            end
                            else if (!door_n)
                            begin
                                mode_next = MODE_FOOD;
                            end
                            else
                            begin
                                mode_next = MODE_BOTH;
                            end
                        end
                    end
                end
                // idle timeout
                if (period_next == idle_reg)
                begin
                    idle_hit    = 1'b1;
                    set_next    = 14'd0;
                    period_next = 8'd0;
                    press_next  = 8'd0;
                    mode_next   = MODE_SET;
                end
                // new digit stored: rebuild time from digit 0 up to it
                if (is_digit && room_left && !idle_hit)
                begin
                    rb_needed   = 1'b1;
                    set_next    = 14'd0;
                    rb_idx_next = '0;
                    rb_end_next = press_reg[IDX_W-1:0];
                end
            end
        end
        else if (cmd.rb_step)
        begin
            set_next    = acc_sat;
            rb_idx_next = rb_idx_reg + IDX_W'(1);
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pps_reg  <= PPS_RESET;
            idle_reg <= IDLE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_PPS)
            begin
                pps_reg <= cfg_data;
            end
            else if (cfg_index == CFG_IDLE)
            begin
                idle_reg <= cfg_data;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_SET;
            heat_reg   <= 1'b0;
            door_reg   <= 1'b0;
            food_reg   <= 1'b0;
            set_reg    <= 14'd0;
            left_reg   <= 14'd0;
            period_reg <= 8'd0;
            press_reg  <= 8'd0;
            for (int i = 0; i < MAX_DIGITS; i++)
            begin
                digit_reg[i] <= 4'd0;
            end
        end
        else
        begin
            mode_reg   <= mode_next;
            heat_reg   <= heat_next;
            door_reg   <= door_next;
            food_reg   <= food_next;
            set_reg    <= set_next;
            left_reg   <= left_next;
            period_reg <= period_next;
            press_reg  <= press_next;
            digit_reg  <= digit_next;
        end
    end

    // Key capture, rebuild indices and result word: payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            key_reg <= key_code;
        end
        rb_idx_reg <= rb_idx_next;
        rb_end_reg <= rb_end_next;
        if (cmd.out_load)
        begin
            mode         <= mode_reg;
            heating_on   <= heat_reg;
            door_open    <= door_reg;
            no_food      <= food_reg;
            entered_time <= set_reg;
            time_left    <= left_reg;
        end
    end

endmodule

// File: rtl/oven_timer_mode_controller_core.sv
// Top level of the oven timer mode controller: controller and datapath.
//
// One input word is one control period carrying a key code; one result word
// follows each, showing mode, heater, door and food flags, entered time and
// time left after that period. A word is taken in the cycle after the
// previous result has been loaded into the output register. Each word
// passes through a step state and a finish state, which loads the output
// register once it is free; a stored digit adds a rebuild state between
// them, since the entered time is rebuilt by a multiply-by-ten-and-add
// unit that takes one stored digit per cycle, from digit 0 up to the new
// one. The output register lets a finished result wait for the consumer
// while the next word is being accepted. Configuration writes are taken
// on every cycle (cfg_ready is held high); indexes beyond the two
// registers are ignored.
module oven_timer_mode_controller_core
    import otmc_pkg::*;
#(
    parameter int MAX_DIGITS = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           key_code,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           mode,
    output logic                 heating_on,
    output logic                 door_open,
    output logic                 no_food,
    output logic [13:0]          entered_time,
    output logic [13:0]          time_left,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    otmc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    otmc_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_code     (key_code),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .mode         (mode),
        .heating_on   (heating_on),
        .door_open    (door_open),
        .no_food      (no_food),
        .entered_time (entered_time),
        .time_left    (time_left)
    );

endmodule

// File: tb/oven_timer_mode_controller_core_test.sv
// Self-checking testbench for the oven timer mode controller core.
module oven_timer_mode_controller_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import otmc_pkg::*;

    localparam int                   DIGIT_SLOTS    = 4;
    localparam logic [7:0]           KEY_NONE       = 8'hFF;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE      = 2'd3;
    localparam int                   WAIT_MAX       = 14;
    localparam int                   PHASE_WORDS    = 200;
    localparam int                   BURST_DIGITS   = 300;
    localparam int                   SETTLE_CYCLES  = 20;
    localparam int                   WATCHDOG_LIMIT = 2000;
    localparam int                   PRINT_LIMIT    = 50;
    localparam int                   OPENING_ROWS   = 25;

    // What the block shows after one control period
    typedef struct packed {
        logic [2:0]  mode;
        logic        heat;
        logic        door;
        logic        nofood;
        logic [13:0] entered;
        logic [13:0] left;
    } oven_view_t;

    // Opening key sequence; pinned rows carry a hand-written expectation
    typedef struct packed {
        logic [7:0] key;
        logic       pinned;
        oven_view_t view;
    } key_row_t;

    localparam key_row_t OPENING_KEYS [OPENING_ROWS] = '{
        '{KEY_NONE, 1'b1, '{MODE_SET,  1'b0, 1'b0, 1'b0, 14'd0,    14'd0}},
        '{8'd9,     1'b1, '{MODE_SET,  1'b0, 1'b0, 1'b0, 14'd9,    14'd0}},
        '{8'd9,     1'b1, '{MODE_SET,  1'b0, 1'b0, 1'b0, 14'd99,   14'd0}},
        '{8'd9,     1'b1, '{MODE_SET,  1'b0, 1'b0, 1'b0, 14'd999,  14'd0}},
        '{8'd9,     1'b1, '{MODE_SET,  1'b0, 1'b0, 1'b0, 14'd9999, 14'd0}},
        // digit beyond the fourth is counted but not stored
        '{8'd0,     1'b1, '{MODE_SET,  1'b0, 1'b0, 1'b0, 14'd9999, 14'd0}},
        '{KEY_A,    1'b1, '{MODE_SET,  1'b0, 1'b0, 1'b1, 14'd9999, 14'd0}},
        '{KEY_D,    1'b1, '{MODE_FOOD, 1'b0, 1'b0, 1'b1, 14'd9999, 14'd0}},
        '{KEY_B,    1'b0, '0},
        '{KEY_D,    1'b1, '{MODE_BOTH, 1'b0, 1'b1, 1'b1, 14'd9999, 14'd0}},
        '{KEY_A,    1'b0, '0},
        '{KEY_D,    1'b1, '{MODE_DOOR, 1'b0, 1'b1, 1'b0, 14'd9999, 14'd0}},
        '{KEY_B,    1'b0, '0},
        '{KEY_D,    1'b1, '{MODE_HEAT, 1'b1, 1'b0, 1'b0, 14'd9999, 14'd9999}},
        '{8'd200,   1'b0, '0},
        '{8'd10,    1'b0, '0},
        '{8'd69,    1'b0, '0},
        // pause on door open, close, resume, abort
        '{KEY_B,    1'b0, '0},
        '{KEY_B,    1'b0, '0},
        '{KEY_D,    1'b0, '0},
        '{KEY_C,    1'b0, '0},
        '{KEY_C,    1'b0, '0},
        // start with nothing entered
        '{KEY_D,    1'b0, '0},
        '{8'd1,     1'b0, '0},
        '{KEY_D,    1'b0, '0}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           key_code = KEY_NONE;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [2:0]           mode;
    logic                 heating_on;
    logic                 door_open;
    logic                 no_food;
    logic [13:0]          entered_time;
    logic [13:0]          time_left;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data = '0;

    // Controller copy kept by the testbench
    logic [7:0]  tick_rate;
    logic [7:0]  idle_limit;
    logic [2:0]  ctl_mode = MODE_SET;
    logic        ctl_heat = 1'b0;
    logic        ctl_door = 1'b0;
    logic        ctl_nofood = 1'b0;
    logic [13:0] ctl_entered = '0;
    logic [13:0] ctl_left = '0;
    logic [7:0]  ctl_periods = '0;
    logic [7:0]  ctl_presses = '0;
    logic [3:0]  ctl_digits [DIGIT_SLOTS] = '{default: '0};

    oven_view_t pending_views [$];

    bit in_quiet = 1'b0;
    bit out_quiet = 1'b0;
    int stall_left = 0;
    int idle_cycles = 0;
    int keys_sent = 0;
    int results_checked = 0;
    int settings_used = 1;
    int heat_runs_done = 0;
    int mismatches = 0;

    oven_timer_mode_controller_core #(.MAX_DIGITS(DIGIT_SLOTS)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .key_code(key_code),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .mode(mode),
        .heating_on(heating_on),
        .door_open(door_open),
        .no_food(no_food),
        .entered_time(entered_time),
        .time_left(time_left),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Entry cleared: cancel, heating end, idle timeout
    function automatic void drop_entry();
        ctl_entered = '0;
        ctl_periods = '0;
        ctl_presses = '0;
        ctl_mode = MODE_SET;
    endfunction

    // One control period of the controller; returns the view after it
    function automatic oven_view_t advance_controller(input logic [7:0] key);
        int acc;
        oven_view_t view;
        if (key == KEY_A)
            ctl_nofood = ~ctl_nofood;
        else if (key == KEY_B)
            ctl_door = ~ctl_door;
        ctl_periods = ctl_periods + 8'd1;

        if (ctl_mode == MODE_HEAT)
        begin
            if (key == KEY_B)
            begin
                ctl_heat = 1'b0;
                ctl_mode = MODE_DOOR;
                ctl_entered = ctl_left;
            end
            else if (key == KEY_C || ctl_left == '0)
            begin
                if (key != KEY_C)
                    heat_runs_done++;
                drop_entry();
                ctl_heat = 1'b0;
            end
            // one-second tick, still taken on the pause period
            if (ctl_periods == tick_rate)
            begin
                ctl_periods = '0;
                if (ctl_left != '0)
                    ctl_left = ctl_left - 14'd1;
            end
        end
        else
        begin
            if (key < DIGIT_LIMIT)
            begin
                ctl_periods = '0;
                ctl_mode = MODE_SET;
                if (ctl_presses < DIGIT_SLOTS)
                begin
                    ctl_digits[ctl_presses] = key[3:0];
                    acc = 0;
                    for (int i = 0; i <= int'(ctl_presses) && i < DIGIT_SLOTS; i++)
                    begin
                        acc = acc * 10 + int'(ctl_digits[i]);
                        if (acc > int'(TIME_MAX))
                            acc = int'(TIME_MAX);
                    end
                    ctl_entered = acc[13:0];
                end
                ctl_presses = ctl_presses + 8'd1;
            end
            else if (key == KEY_C)
                drop_entry();
            else if (key == KEY_D)
            begin
                ctl_periods = '0;
                if (ctl_entered != '0)
                begin
                    if (!ctl_nofood && !ctl_door)
                    begin
                        ctl_left = ctl_entered;
                        ctl_heat = 1'b1;
                        ctl_mode = MODE_HEAT;
                    end
                    else
                    begin
                        ctl_heat = 1'b0;
                        if (!ctl_nofood)
                            ctl_mode = MODE_DOOR;
                        else if (!ctl_door)
                            ctl_mode = MODE_FOOD;
                        else
                            ctl_mode = MODE_BOTH;
                    end
                end
            end
            if (ctl_periods == idle_limit)
                drop_entry();
        end

        view = '{ctl_mode, ctl_heat, ctl_door, ctl_nofood, ctl_entered, ctl_left};
        return view;
    endfunction

    // A byte that is neither a digit nor a command key
    function automatic logic [7:0] idle_key();
        logic [7:0] k;
        k = 8'($urandom_range(DIGIT_LIMIT, 255));
        if (k >= KEY_A && k <= KEY_D)
            k = KEY_NONE;
        return k;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("MISMATCH at %0t ns: %s got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Offer one key word; returns at the edge that accepts it
    task automatic send_key(input logic [7:0] k, input logic pinned,
                            input oven_view_t pinned_view);
        int gap;
        oven_view_t view;
        gap = in_quiet ? 0 : $urandom_range(0, WAIT_MAX);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        key_code <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        view = advance_controller(k);
        pending_views.push_back(pinned ? pinned_view : view);
        keys_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
    endtask

    // Valid is held across back-to-back writes; the caller lowers it
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_PPS)
            tick_rate = value;
        else if (idx == CFG_IDLE)
            idle_limit = value;
    endtask

    task automatic apply_settings(input logic [7:0] pps, input logic [7:0] idle,
                                  input bit spare);
        write_register(CFG_PPS, pps);
        write_register(CFG_IDLE, idle);
        if (spare)
            write_register(CFG_SPARE, 8'($urandom_range(0, 255)));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Mostly complete cooking cycles with random content, some noise
    task automatic run_session();
        logic [7:0] plan [$];
        int digits;
        in_quiet = ($urandom_range(0, 3) == 0);
        out_quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) < 7)
        begin
            if (ctl_mode == MODE_HEAT && $urandom_range(0, 1) == 1)
                plan.push_back(KEY_C);
            // usually put the sensors right first
            if ($urandom_range(0, 4) != 0)
            begin
                if (ctl_nofood)
                    plan.push_back(KEY_A);
                if (ctl_door)
                    plan.push_back(KEY_B);
            end
            // leading zeros keep most times short
            digits = $urandom_range(1, DIGIT_SLOTS + 1);
            for (int i = 0; i < digits; i++)
                plan.push_back((i < digits - 1 && $urandom_range(0, 9) < 7)
                               ? 8'd0 : 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 4) == 0)
                plan.push_back($urandom_range(0, 1) ? KEY_A : KEY_B);
            plan.push_back(KEY_D);
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(0, 40))
                plan.push_back(idle_key());
            // pause and resume
            if ($urandom_range(0, 4) == 0)
            begin
                plan.push_back(KEY_B);
                repeat ($urandom_range(0, 5))
                    plan.push_back(idle_key());
                plan.push_back(KEY_B);
                plan.push_back(KEY_D);
                repeat ($urandom_range(0, 20))
                    plan.push_back(idle_key());
            end
            if ($urandom_range(0, 5) == 0)
                plan.push_back(KEY_C);
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                plan.push_back(($urandom_range(0, 3) == 0)
                               ? 8'(KEY_A + 8'($urandom_range(0, 3)))
                               : 8'($urandom_range(0, 255)));
        end
        foreach (plan[i])
            send_key(plan[i], 1'b0, '0);
    endtask

    // Result side: check each accepted word, then draw the next stall
    always @(posedge clk)
    begin
        oven_view_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (pending_views.size() == 0)
                report_mismatch("unrequested result, entered_time", entered_time, 0);
            else
            begin
                want = pending_views.pop_front();
                if (mode !== want.mode)
                    report_mismatch("mode", mode, want.mode);
                if (heating_on !== want.heat)
                    report_mismatch("heating_on", heating_on, want.heat);
                if (door_open !== want.door)
                    report_mismatch("door_open", door_open, want.door);
                if (no_food !== want.nofood)
                    report_mismatch("no_food", no_food, want.nofood);
                if (entered_time !== want.entered)
                    report_mismatch("entered_time", entered_time, want.entered);
                if (time_left !== want.left)
                    report_mismatch("time_left", time_left, want.left);
            end
            stall_left = out_quiet ? 0 : $urandom_range(0, WAIT_MAX);
            out_stall <= (stall_left != 0);
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            out_stall <= (stall_left != 0);
        end
    end

    // Watchdog: too long without any handshake
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        int phase_start;
        tick_rate = PPS_RESET;
        idle_limit = IDLE_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int row = 0; row < OPENING_ROWS; row++)
            send_key(OPENING_KEYS[row].key, OPENING_KEYS[row].pinned, OPENING_KEYS[row].view);
        drain_results();

        for (int phase = 1; phase <= 6; phase++)
        begin
            case (phase)
                1: apply_settings(8'd1, 8'd255, 1'b0);
                2: apply_settings(8'd255, 8'd1, 1'b0);
                3: apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
                4: apply_settings(8'd0, 8'd0, 1'b0);
                5: apply_settings(8'd3, 8'd20, 1'b0);
                default: apply_settings(8'($urandom_range(1, 8)),
                                        8'($urandom_range(10, 80)), 1'b0);
            endcase
            // long digit run so the press counter wraps
            if (phase == 5)
            begin
                send_key(KEY_C, 1'b0, '0);
                repeat (BURST_DIGITS)
                    send_key(8'($urandom_range(0, 9)), 1'b0, '0);
            end
            phase_start = keys_sent;
            while (keys_sent - phase_start < PHASE_WORDS)
                run_session();
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_views.size() != 0)
            report_mismatch("results still outstanding", 0, pending_views.size());

        $display("Run covered %0d key words under %0d register settings, %0d results checked.",
                 keys_sent, settings_used, results_checked);
        $display("Heating ran down to zero %0d times; %0d mismatches.",
                 heat_runs_done, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/otmc_pkg.sv
rtl/otmc_ctrl.sv
rtl/otmc_dp.sv
rtl/oven_timer_mode_controller_core.sv
tb/oven_timer_mode_controller_core_test.sv
